FILE: hdl/fgks_pkg.sv
// Shared constants and the sequencer state type for the k-th successor block.
// Used by fgks_rem, functional_graph_kth_successor_top, fgks_chk and the bench; no dependencies.
`default_nettype none

package fgks_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int LEN_W     = NODE_W + 1;     // path length, holds MAX_NODES itself
  localparam int STEP_W    = 30;
  localparam int STAMP_W   = 16;
  localparam int S_TDATA_W = ((2 * NODE_W + STEP_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((NODE_W + 7) / 8) * 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STAMP_W-1:0] STAMP_FIRST = STAMP_W'(1);
  localparam logic [STAMP_W-1:0] STAMP_LAST  = {STAMP_W{1'b1}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_WALK,
    ST_MOD,
    ST_PATH,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: hdl/fgks_rem.sv
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on fgks_pkg for the dividend and length widths.
`default_nettype none

module fgks_rem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fgks_pkg::STEP_W-1:0] dividend,
  input  logic [fgks_pkg::LEN_W-1:0]  divisor,
  output logic                      done,
  output logic [fgks_pkg::LEN_W-1:0]  rem
);
  import fgks_pkg::*;

  localparam int CNT_W = $clog2(STEP_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [STEP_W-1:0]  dvd;
  logic [LEN_W-1:0]   dsr;
  logic [LEN_W:0]     trial;
  logic               fits;

  // remainder stays below the divisor, so one extra bit covers the shifted value
  assign trial = {rem, dvd[STEP_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(STEP_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(STEP_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[STEP_W-2:0], 1'b0};
      if (fits) begin
        rem <= LEN_W'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[LEN_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/functional_graph_kth_successor_top.sv
// k-th successor engine over a stored functional graph, with cycle shortcut.
// Depends on fgks_pkg and fgks_rem.
//
//  channel   | direction | tdata (low bit up)                 | tuser
//  s_axis    | in        | node, next_node, steps, zero pad   | cmd
//  m_axis    | out       | result_node, zero pad              | is_answer
//
// A query walks w steps, w at most k and at most MAX_NODES, at one successor read per
// cycle; zero steps skip the walk, and a revisit adds the bit-serial remainder and a
// path read. The input is ready only when the sequencer is idle. After reset, and
// after every 65535 queries, a sweep clears the visit stamps of all MAX_NODES nodes;
// no request is taken meanwhile.
// A stalled result holds in the output register while the next request may be taken.
`default_nettype none

module functional_graph_kth_successor_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [9:0] node, [19:10] next_node, [49:20] steps, [55:50] zero
  input  logic [fgks_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] result_node, [15:10] zero
  output logic [fgks_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] is_answer
  output logic                             m_axis_tuser
);
  import fgks_pkg::*;

  // memories
  logic [NODE_W-1:0]  succ_mem  [MAX_NODES];
  logic [NODE_W-1:0]  path_mem  [MAX_NODES];
  logic [NODE_W-1:0]  pos_mem   [MAX_NODES];
  logic [STAMP_W-1:0] stamp_mem [MAX_NODES];

  state_t state, state_next;

  logic [NODE_W-1:0]  y;
  logic [STEP_W-1:0]  k;
  logic [STEP_W-1:0]  taken;
  logic [LEN_W-1:0]   len;
  logic [STAMP_W-1:0] cur;
  logic [NODE_W-1:0]  p;
  logic               byp;
  logic [NODE_W-1:0]  byp_pos;
  logic [NODE_W-1:0]  clr_addr;
  logic [NODE_W-1:0]  res_node;
  logic               res_ans;

  logic [NODE_W-1:0]  succ_rd;
  logic [NODE_W-1:0]  pos_rd;
  logic [STAMP_W-1:0] stamp_rd;
  logic [NODE_W-1:0]  path_rd;

  // memory controls
  logic               succ_we;
  logic [NODE_W-1:0]  succ_wa;
  logic [NODE_W-1:0]  succ_wd;
  logic [NODE_W-1:0]  rd_addr;
  logic               walk_we;
  logic [NODE_W-1:0]  walk_wa;
  logic [NODE_W-1:0]  path_wa;
  logic [NODE_W-1:0]  pos_wd;
  logic               stamp_we;
  logic [NODE_W-1:0]  stamp_wa;
  logic [STAMP_W-1:0] stamp_wd;
  logic [NODE_W-1:0]  path_ra;

  logic               s_acc;
  logic               m_free;
  logic               visited;
  logic [NODE_W-1:0]  pos_eff;
  logic               len_room;

  logic               rem_start;
  logic               rem_done;
  logic [LEN_W-1:0]   rem;

  logic [NODE_W-1:0]  in_node;
  logic [NODE_W-1:0]  in_next;
  logic [STEP_W-1:0]  in_steps;

  assign in_node  = s_axis_tdata[NODE_W-1:0];
  assign in_next  = s_axis_tdata[2*NODE_W-1:NODE_W];
  assign in_steps = s_axis_tdata[2*NODE_W+STEP_W-1:2*NODE_W];

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign m_free   = !m_axis_tvalid || m_axis_tready;
  assign visited  = byp || (stamp_rd == cur);
  assign pos_eff  = byp ? byp_pos : pos_rd;
  assign len_room = !len[LEN_W-1];

  fgks_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (k - STEP_W'(pos_eff)),
    .divisor  (len - LEN_W'(pos_eff)),
    .done     (rem_done),
    .rem      (rem)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == NODE_W'(MAX_NODES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_acc) state_next = (s_axis_tuser == CMD_QUERY) ? ST_START : ST_RESP;
      end
      ST_START: state_next = (k == '0) ? ST_RESP : ST_FETCH;
      ST_FETCH: state_next = ST_WALK;
      ST_WALK: begin
        if (visited)         state_next = ST_MOD;
        else if (taken == k) state_next = ST_RESP;
      end
      ST_MOD:  if (rem_done) state_next = ST_PATH;
      ST_PATH: state_next = ST_RESP;
      ST_RESP: begin
        if (m_free) begin
          state_next = (res_ans && cur == STAMP_LAST) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    s_axis_tready = 1'b0;
    succ_we   = 1'b0;
    succ_wa   = in_node;
    succ_wd   = in_next;
    rd_addr   = y;
    walk_we   = 1'b0;
    walk_wa   = y;
    path_wa   = len[NODE_W-1:0];
    pos_wd    = len[NODE_W-1:0];
    stamp_we  = 1'b0;
    stamp_wa  = y;
    stamp_wd  = cur;
    path_ra   = NODE_W'(p + rem[NODE_W-1:0]);
    rem_start = 1'b0;
    case (state)
      ST_CLEAR: begin
        stamp_we = 1'b1;
        stamp_wa = clr_addr;
        stamp_wd = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        succ_we = s_acc && (s_axis_tuser == CMD_WRITE);
      end
      ST_START: begin
        walk_we  = 1'b1;
        stamp_we = 1'b1;
        path_wa  = '0;
        pos_wd   = '0;
      end
      ST_FETCH: rd_addr = succ_rd;
      ST_WALK: begin
        rd_addr   = succ_rd;
        rem_start = visited;
        walk_we   = !visited && len_room;
        stamp_we  = !visited && len_room;
      end
      default: ;
    endcase
  end

  // memories: one write and one read address each, registered read data
  always_ff @(posedge clk) begin
    if (succ_we) succ_mem[succ_wa] <= succ_wd;
    succ_rd <= succ_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (walk_we) begin
      path_mem[path_wa] <= walk_wa;
      pos_mem[walk_wa]  <= pos_wd;
    end
    pos_rd  <= pos_mem[rd_addr];
    path_rd <= path_mem[path_ra];
  end

  always_ff @(posedge clk) begin
    if (stamp_we) stamp_mem[stamp_wa] <= stamp_wd;
    stamp_rd <= stamp_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      cur           <= STAMP_FIRST;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + NODE_W'(1);
      if (state == ST_RESP && m_free) begin
        m_axis_tvalid <= 1'b1;
        if (res_ans) begin
          cur <= (cur == STAMP_LAST) ? STAMP_FIRST : cur + STAMP_W'(1);
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        y        <= in_node;
        k        <= in_steps;
        res_node <= '0;
        res_ans  <= (s_axis_tuser == CMD_QUERY);
      end
      ST_START: begin
        len      <= LEN_W'(1);
        taken    <= STEP_W'(1);
        res_node <= y;
      end
      ST_FETCH: begin
        y   <= succ_rd;
        byp <= 1'b0;
      end
      ST_WALK: begin
        p <= pos_eff;
        if (!visited) begin
          if (len_room) len <= len + LEN_W'(1);
          res_node <= y;
          taken    <= taken + STEP_W'(1);
          y        <= succ_rd;
          // self step onto the node being recorded this cycle
          byp      <= len_room && (succ_rd == y);
          byp_pos  <= len[NODE_W-1:0];
        end
      end
      ST_PATH: res_node <= path_rd;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESP && m_free) begin
      m_axis_tdata <= M_TDATA_W'(res_node);
      m_axis_tuser <= res_ans;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/fgks_chk.sv
// Port-level checks for functional_graph_kth_successor_top, bound to it below.
// Depends on fgks_pkg for the port widths.
`default_nettype none

module fgks_chk (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [fgks_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [fgks_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tuser
);
  import fgks_pkg::*;

  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while the previous one is in work");

  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("write acknowledge carries a nonzero node");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind functional_graph_kth_successor_top fgks_chk u_fgks_chk (.*);

`default_nettype wire

FILE: sim/tb_functional_graph_kth_successor_top.sv
// Self-checking bench for functional_graph_kth_successor_top: successor writes and
// k-step queries, with a built-in walk predictor and an in-order result check.
// Depends on fgks_pkg and the block's RTL; nothing else.

class walk_scoreboard;
  localparam int NODES = fgks_pkg::MAX_NODES;
  localparam int NW    = fgks_pkg::NODE_W;

  typedef struct {
    logic [NW-1:0] node;
    logic          is_answer;
  } reply_t;

  logic [NW-1:0]                succ_table [NODES];
  bit                           written    [NODES];
  int                           written_nodes [$];
  logic [NW-1:0]                path_nodes [NODES];
  int unsigned                  visit_pos  [NODES];
  logic [fgks_pkg::STAMP_W-1:0] visit_mark [NODES];
  logic [fgks_pkg::STAMP_W-1:0] walk_mark;
  reply_t                       due_replies [$];
  int                           mismatches;
  int                           replies_seen;

  function new();
    foreach (visit_mark[i]) visit_mark[i] = '0;
    walk_mark    = fgks_pkg::STAMP_FIRST;
    mismatches   = 0;
    replies_seen = 0;
  endfunction

  // Node reached after k steps, shortcutting through the first repeated node.
  function logic [NW-1:0] kth_node(logic [NW-1:0] start, int unsigned k);
    int unsigned len, taken, p, cyc, idx;
    logic [NW-1:0] y;
    path_nodes[0]     = start;
    visit_pos[start]  = 0;
    visit_mark[start] = walk_mark;
    len   = 1;
    taken = 0;
    y     = start;
    while (taken < k) begin
      taken++;
      y = succ_table[y];
      if (visit_mark[y] == walk_mark) begin
        p   = visit_pos[y];
        cyc = len - p;
        idx = p + (k - p) % cyc;
        return path_nodes[idx % NODES];
      end
      if (len < NODES) begin
        path_nodes[len] = y;
        visit_pos[y]    = len;
        visit_mark[y]   = walk_mark;
        len++;
      end
    end
    return y;
  endfunction

  function void note_request(logic cmd, logic [NW-1:0] node, logic [NW-1:0] succ,
                             logic [fgks_pkg::STEP_W-1:0] steps);
    reply_t r;
    if (cmd == fgks_pkg::CMD_WRITE) begin
      if (!written[node]) begin
        written[node] = 1'b1;
        written_nodes = {written_nodes, int'(node)};
      end
      succ_table[node] = succ;
      r.node      = '0;
      r.is_answer = 1'b0;
    end else begin
      r.node      = kth_node(node, steps);
      r.is_answer = 1'b1;
      // stamps are swept once the counter runs out
      if (walk_mark == fgks_pkg::STAMP_LAST) begin
        foreach (visit_mark[i]) visit_mark[i] = '0;
        walk_mark = fgks_pkg::STAMP_FIRST;
      end else begin
        walk_mark++;
      end
    end
    due_replies = {due_replies, r};
  endfunction

  function void check_result(logic [fgks_pkg::M_TDATA_W-1:0] tdata, logic tuser);
    reply_t r;
    replies_seen++;
    if (due_replies.size() == 0) begin
      $error("unexpected result: result_node=%0d is_answer=%0b", tdata[NW-1:0], tuser);
      mismatches++;
      return;
    end
    r = due_replies.pop_front();
    if (tdata[NW-1:0] !== r.node) begin
      $error("result_node: expected %0d, actual %0d", r.node, tdata[NW-1:0]);
      mismatches++;
    end
    if (tuser !== r.is_answer) begin
      $error("is_answer: expected %0b, actual %0b", r.is_answer, tuser);
      mismatches++;
    end
    if (tdata[fgks_pkg::M_TDATA_W-1:NW] !== '0) begin
      $error("tdata pad: expected 0, actual %0h", tdata[fgks_pkg::M_TDATA_W-1:NW]);
      mismatches++;
    end
  endfunction

  function int outstanding();
    return due_replies.size();
  endfunction

  // First node whose successor a walk of k steps would read before it was ever
  // written, or -1 when the walk stays on written entries.
  function int first_unwritten(logic [NW-1:0] start, int unsigned k);
    bit seen [NODES];
    logic [NW-1:0] y;
    int unsigned taken;
    y       = start;
    seen[y] = 1'b1;
    taken   = 0;
    while (taken < k) begin
      if (!written[y]) return y;
      taken++;
      y = succ_table[y];
      if (seen[y]) return -1;
      seen[y] = 1'b1;
    end
    return -1;
  endfunction

  function logic [NW-1:0] any_written();
    if (written_nodes.size() == 0) return NW'($urandom_range(0, NODES - 1));
    return NW'(written_nodes[$urandom_range(0, written_nodes.size() - 1)]);
  endfunction
endclass

module tb_functional_graph_kth_successor_top;
  import fgks_pkg::*;

  localparam int          NODES     = MAX_NODES;
  localparam int          ITEMS     = 540;
  localparam logic [29:0] STEPS_MAX = {STEP_W{1'b1}};

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  walk_scoreboard book;
  bit             no_idle = 1'b0;
  bit             held_once = 1'b0;
  int             hold_left = 0;
  int             sent_items = 0;

  functional_graph_kth_successor_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off to fill the block.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (!held_once && book != null && book.replies_seen >= 120) begin
        held_once = 1'b1;
        hold_left = 400;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata, m_axis_tuser);
  end

  // Called at a rising edge; returns at the edge that accepts the request.
  task automatic send_req(input logic cmd, input logic [NODE_W-1:0] node,
                          input logic [NODE_W-1:0] succ, input logic [STEP_W-1:0] steps);
    while (!no_idle && $urandom_range(0, 99) < 14) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= S_TDATA_W'({steps, succ, node});
    do @(posedge clk); while (!s_axis_tready);
    book.note_request(cmd, node, succ, steps);
    sent_items++;
  endtask

  function automatic logic [STEP_W-1:0] pick_steps();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return STEP_W'($urandom_range(1, 8));
      2:       return STEP_W'($urandom_range(1, 400));
      3:       return STEPS_MAX;
      4:       return r[STEP_W-1:0] >> $urandom_range(0, STEP_W - 1);
      default: return STEP_W'($urandom_range(1000, 1100));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] junk_steps();
    logic [31:0] r;
    r = $urandom;
    return r[STEP_W-1:0];
  endfunction

  // Fill in any successor the walk would read unwritten, then ask the query.
  task automatic query_walk(input logic [NODE_W-1:0] node, input logic [STEP_W-1:0] steps);
    int miss;
    miss = book.first_unwritten(node, steps);
    while (miss >= 0) begin
      send_req(CMD_WRITE, NODE_W'(miss), book.any_written(), junk_steps());
      miss = book.first_unwritten(node, steps);
    end
    send_req(CMD_QUERY, node, NODE_W'($urandom), steps);
  endtask

  // A chain of fresh writes closed into itself, the existing graph or a random node, then walks on it.
  task automatic build_chain();
    int            len;
    logic [NODE_W-1:0] nodes [$];
    logic [NODE_W-1:0] tgt;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
    // keep the run near its item budget
    if (len > ITEMS - sent_items) len = ITEMS - sent_items;
    if (len < 1) len = 1;
    repeat (len) nodes = {nodes, NODE_W'($urandom_range(0, NODES - 1))};
    for (int i = 0; i < len; i++) begin
      if (i < len - 1) begin
        tgt = nodes[i + 1];
      end else begin
        case ($urandom_range(0, 2))
          0:       tgt = nodes[$urandom_range(0, len - 1)];
          1:       tgt = book.any_written();
          default: tgt = NODE_W'($urandom_range(0, NODES - 1));
        endcase
      end
      send_req(CMD_WRITE, nodes[i], tgt, junk_steps());
    end
    repeat ($urandom_range(2, 5)) query_walk(nodes[$urandom_range(0, len - 1)], pick_steps());
  endtask

  initial begin
    book = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: zero steps on unwritten nodes, edge node numbers, self-loop,
    // a tail into a loop of three nodes, huge step counts, ignored fields all ones
    send_req(CMD_QUERY, 10'd1023, 10'd0,    30'd0);
    send_req(CMD_QUERY, 10'd0,    10'd1023, 30'd0);
    send_req(CMD_WRITE, 10'd0,    10'd1023, STEPS_MAX);
    send_req(CMD_WRITE, 10'd1023, 10'd0,    30'd0);
    send_req(CMD_WRITE, 10'd512,  10'd512,  30'd0);
    send_req(CMD_WRITE, 10'd1,    10'd2,    30'd7);
    send_req(CMD_WRITE, 10'd2,    10'd3,    30'd0);
    send_req(CMD_WRITE, 10'd3,    10'd1,    30'd0);
    send_req(CMD_WRITE, 10'd4,    10'd1,    30'd0);
    send_req(CMD_WRITE, 10'd1000, 10'd4,    STEPS_MAX);
    send_req(CMD_QUERY, 10'd0,    10'd0,    30'd1);
    send_req(CMD_QUERY, 10'd0,    10'd1023, STEPS_MAX);
    send_req(CMD_QUERY, 10'd1023, 10'd0,    30'd2);
    send_req(CMD_QUERY, 10'd512,  10'd0,    STEPS_MAX);
    send_req(CMD_QUERY, 10'd512,  10'd0,    30'd1);
    send_req(CMD_QUERY, 10'd4,    10'd0,    30'd0);
    send_req(CMD_QUERY, 10'd4,    10'd0,    30'd1);
    send_req(CMD_QUERY, 10'd4,    10'd1023, STEPS_MAX);
    send_req(CMD_QUERY, 10'd1000, 10'd0,    30'd3);
    send_req(CMD_QUERY, 10'd1000, 10'd1023, 30'd1024);
    send_req(CMD_QUERY, 10'd3,    10'd0,    30'd5);
    send_req(CMD_WRITE, 10'd2,    10'd2,    30'd0);
    send_req(CMD_QUERY, 10'd4,    10'd0,    30'd12345);

    // random mix; a stretch in the middle runs with no idling on either side
    while (sent_items < ITEMS) begin
      no_idle = (sent_items >= 200) && (sent_items < 320);
      case ($urandom_range(0, 99)) inside
        [0:54]:  build_chain();
        [55:84]: query_walk(($urandom_range(0, 3) == 0) ? NODE_W'($urandom_range(0, NODES - 1))
                                                        : book.any_written(), pick_steps());
        default: send_req(CMD_WRITE, NODE_W'($urandom_range(0, NODES - 1)),
                          NODE_W'($urandom_range(0, NODES - 1)), junk_steps());
      endcase
    end
    no_idle = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (book.outstanding() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
